FILE: src/pmpu_pkg.sv
// Shared types, codes and the acceptance exp table of the Potts pixel update core.
// No dependencies; every other file except pmpu_div refers to it by scoped names.
package pmpu_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD_Q  = 2'd0;
  localparam logic [1:0] KIND_LOAD_L  = 2'd1;
  localparam logic [1:0] KIND_PROPOSE = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_BINS     = 3'd0;
  localparam logic [2:0] CFG_GRID_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_BETA         = 3'd3;
  localparam logic [2:0] CFG_INV_TWO_VAR  = 3'd4;
  localparam logic [2:0] CFG_INV_TEMP     = 3'd5;
  localparam logic [2:0] CFG_ACCEPT_SCALE = 3'd6;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] EXP_STEP = 64'd4034748382;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [9:0]  observed;
    logic [5:0]  label_in;
    logic [15:0] uniform;
  } in_item_t;

  typedef struct packed {
    logic [5:0] label_out;
    logic       accepted;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  num_bins;
    logic [8:0]  grid_width;
    logic [8:0]  grid_height;
    logic [15:0] beta;
    logic [15:0] inv_two_variance;
    logic [15:0] inv_temperature;
    logic [15:0] accept_scale;
  } cfg_t;

  // Classified item between front and back; nbr_ok: up, down, right, left
  typedef struct packed {
    logic [1:0]  kind;
    logic        oob;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [9:0]  observed;
    logic [5:0]  label;
    logic [15:0] uniform;
    logic [3:0]  nbr_ok;
    logic [6:0]  nb;
  } job_t;

  // Build the exp table once at elaboration: entry k is exp(-k/16) in Q0.16
  function automatic logic [255:0][15:0] build_exp();
    logic [255:0][15:0] tab;
    logic [63:0]        e;
    e = 64'd65536;
    for (int k = 0; k < 256; k++) begin
      tab[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      e = (e * EXP_STEP + 64'd2147483648) >> 32;
    end
    return tab;
  endfunction

  localparam logic [255:0][15:0] EXP_TABLE = build_exp();

endpackage

FILE: src/pmpu_front.sv
// Front end: saturates the grid settings, checks bounds, quantizes load labels.
// Depends on pmpu_pkg.
module pmpu_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  pmpu_pkg::in_item_t item_i,
  input  pmpu_pkg::cfg_t     cfg_i,
  output pmpu_pkg::job_t     job_o
);

  localparam logic [12:0] MW = 13'(MAX_WIDTH);
  localparam logic [12:0] MH = 13'(MAX_HEIGHT);

  logic [12:0] w_eff, h_eff, row_x, col_x;
  logic [6:0]  nb;
  logic [17:0] qsum;
  logic [7:0]  qlbl;
  logic [5:0]  lbl;

  // Saturate grid size and bin count
  always_comb begin
    w_eff = {4'b0, cfg_i.grid_width};
    if (cfg_i.grid_width == 9'd0) w_eff = 13'd1;
    else if (w_eff > MW)          w_eff = MW;
    h_eff = {4'b0, cfg_i.grid_height};
    if (cfg_i.grid_height == 9'd0) h_eff = 13'd1;
    else if (h_eff > MH)           h_eff = MH;
    nb = cfg_i.num_bins;
    if (nb < 7'd2)       nb = 7'd2;
    else if (nb > 7'd64) nb = 7'd64;
  end

  // Quantize the observed value, clamp to 1..nb-1
  always_comb begin
    qsum = 18'(item_i.observed * nb) + 18'd512;
    qlbl = qsum[17:10];
    if (qlbl < 8'd1)                 qlbl = 8'd1;
    if (qlbl > {1'b0, nb - 7'd1})    qlbl = {1'b0, nb - 7'd1};
    lbl = (item_i.kind == pmpu_pkg::KIND_LOAD_Q) ? qlbl[5:0] : item_i.label_in;
  end

  assign row_x = {5'b0, item_i.row};
  assign col_x = {5'b0, item_i.col};

  // Classify
  always_comb begin
    job_o.kind      = item_i.kind;
    job_o.oob       = (row_x >= h_eff) || (col_x >= w_eff);
    job_o.row       = item_i.row;
    job_o.col       = item_i.col;
    job_o.observed  = item_i.observed;
    job_o.label     = lbl;
    job_o.uniform   = item_i.uniform;
    job_o.nbr_ok[0] = item_i.row != 8'd0;
    job_o.nbr_ok[1] = (row_x + 13'd1) < h_eff;
    job_o.nbr_ok[2] = (col_x + 13'd1) < w_eff;
    job_o.nbr_ok[3] = item_i.col != 8'd0;
    job_o.nb        = nb;
  end

endmodule

FILE: src/pmpu_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on pmpu_pkg.
module pmpu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pmpu_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output pmpu_pkg::job_t pop_data_o
);

  pmpu_pkg::job_t ent_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = ent_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/pmpu_div.sv
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Computes label colours; no package dependency.
module pmpu_div #(
  parameter int NUMW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [6:0]      divisor_i,
  input  logic [NUMW-1:0] num_a_i,
  input  logic [NUMW-1:0] num_b_i,
  output logic            done_o,
  output logic [NUMW-1:0] quo_a_o,
  output logic [NUMW-1:0] quo_b_o
);

  localparam int CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] sh_q [2];
  logic [NUMW-1:0] sh_d [2];
  logic [6:0]      rem_q [2];
  logic [6:0]      rem_d [2];
  logic [6:0]      div_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;

  // One restoring step per lane
  always_comb begin
    logic [7:0] r;
    logic       ge;
    for (int i = 0; i < 2; i++) begin
      r        = {rem_q[i], sh_q[i][NUMW-1]};
      ge       = r >= {1'b0, div_q};
      r        = ge ? r - {1'b0, div_q} : r;
      rem_d[i] = r[6:0];
      sh_d[i]  = {sh_q[i][NUMW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q[0]  <= num_a_i;
      sh_q[1]  <= num_b_i;
      rem_q[0] <= 7'd0;
      rem_q[1] <= 7'd0;
      div_q    <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  // Count iterations, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = sh_q[0];
  assign quo_b_o = sh_q[1];

endmodule

FILE: src/pmpu_back.sv
// Back end: label and observed memories, neighbour fetch, energy and acceptance test.
// Depends on pmpu_pkg and pmpu_div.
module pmpu_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int LABEL_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmpu_pkg::cfg_t     cfg_i,
  input  logic               job_valid_i,
  input  pmpu_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output pmpu_pkg::out_item_t res_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LB    = LABEL_BITS;
  localparam int NUMW  = LB + 10;
  localparam int SQW   = 2 * NUMW;
  localparam int DATW  = SQW + 16;
  localparam int AGW   = 21;
  localparam int DEW   = ((DATW > AGW + 20) ? DATW : AGW + 20) + 2;
  localparam int MAGW  = DEW - 1;
  localparam int HIW   = MAGW - 20;
  localparam int TW    = MAGW + 16;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;

  pmpu_pkg::job_t job_q;
  logic [AW-1:0]  idx_head, idx_q, rd_addr, wr_addr;
  logic [LB-1:0]  lbl_mem [DEPTH];
  logic [9:0]     obs_mem [DEPTH];
  logic [LB-1:0]  rd_lbl_q, wr_lbl;
  logic [9:0]     rd_obs_q;
  logic           lbl_we, obs_we;

  logic [LB-1:0]  ctr_q, cand;
  logic [LB-1:0]  nbr_q [4];
  logic [9:0]     obs_q;
  logic [NUMW-1:0] colc_q, colu_q, quo_a, quo_b, num_a, num_b;
  logic            div_start, div_done;

  logic [SQW-1:0]          sqc_q, squ_q;
  logic signed [AGW-1:0]   agree_q;
  logic [DATW-1:0]         datc_q, datu_q;
  logic [MAGW-1:0]         mag_q;
  logic [35:0]             plo_q;
  logic [HIW+15:0]         phi_q;
  logic [15:0]             e_q, p_q;
  logic                    acc;

  assign idx_head = AW'(AW'(job_i.row) * AW'(MAX_WIDTH)) + AW'(job_i.col);
  assign cand     = LB'(job_q.label);
  assign acc      = job_q.uniform < p_q;

  // Choose the label read address
  always_comb begin
    rd_addr = idx_head;
    case (state_q)
      S_READ:  rd_addr = idx_q;
      S_FETCH: begin
        case (cnt_q)
          3'd1:    rd_addr = idx_q - AW'(MAX_WIDTH);
          3'd2:    rd_addr = idx_q + AW'(MAX_WIDTH);
          3'd3:    rd_addr = idx_q + AW'(1);
          3'd4:    rd_addr = idx_q - AW'(1);
          default: rd_addr = idx_q;
        endcase
      end
      default: rd_addr = idx_head;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[wr_addr] <= wr_lbl;
    rd_lbl_q <= lbl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (obs_we) obs_mem[idx_head] <= job_i.observed;
    rd_obs_q <= obs_mem[idx_q];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    lbl_we      = 1'b0;
    obs_we      = 1'b0;
    wr_addr     = idx_head;
    wr_lbl      = LB'(job_i.label);
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          if (job_i.oob || job_i.kind == pmpu_pkg::KIND_LOAD_Q ||
              job_i.kind == pmpu_pkg::KIND_LOAD_L) begin
            // Loads and out-of-grid items finish at once
            res_valid_o = 1'b1;
            if (!job_i.oob) res_o.label_out = 6'(LB'(job_i.label));
            if (res_ready_i) begin
              pop_o  = 1'b1;
              lbl_we = !job_i.oob;
              obs_we = !job_i.oob;
            end
          end else begin
            pop_o   = 1'b1;
            cnt_d   = 3'd0;
            state_d = (job_i.kind == pmpu_pkg::KIND_READ) ? S_READ : S_FETCH;
          end
        end
      end
      S_READ: begin
        // Issue the read, then show the registered data until it is taken
        cnt_d = 3'd1;
        if (cnt_q == 3'd1) begin
          res_valid_o     = 1'b1;
          res_o.label_out = 6'(rd_lbl_q);
          if (res_ready_i) state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = 3'd0;
        if (div_done) state_d = S_CALC;
      end
      S_CALC: begin
        if (cnt_q != 3'd6) cnt_d = cnt_q + 3'd1;
        else begin
          res_valid_o     = 1'b1;
          res_o.label_out = 6'(acc ? cand : ctr_q);
          res_o.accepted  = acc;
          if (res_ready_i) begin
            lbl_we  = acc;
            wr_addr = idx_q;
            wr_lbl  = cand;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Capture the item and the fetched labels
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_o) begin
      job_q <= job_i;
      idx_q <= idx_head;
    end
    if (state_q == S_FETCH) begin
      case (cnt_q)
        3'd1: begin
          ctr_q <= rd_lbl_q;
          obs_q <= rd_obs_q;
        end
        3'd2:    nbr_q[0] <= rd_lbl_q;
        3'd3:    nbr_q[1] <= rd_lbl_q;
        3'd4:    nbr_q[2] <= rd_lbl_q;
        3'd5:    nbr_q[3] <= rd_lbl_q;
        default: ;
      endcase
    end
    if (state_q == S_DIV && div_done) begin
      colc_q <= quo_a;
      colu_q <= quo_b;
    end
  end

  // Colour numerators: label*1024 + nb/2
  assign num_a = NUMW'({cand, 10'b0}) + NUMW'(job_q.nb[6:1]);
  assign num_b = NUMW'({ctr_q, 10'b0}) + NUMW'(job_q.nb[6:1]);

  pmpu_div #(.NUMW(NUMW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (job_q.nb),
    .num_a_i   (num_a),
    .num_b_i   (num_b),
    .done_o    (div_done),
    .quo_a_o   (quo_a),
    .quo_b_o   (quo_b)
  );

  // Energy pipeline, settles one stage per cycle in S_CALC
  always_ff @(posedge clk_i) begin
    logic [2:0]              nc, nu;
    logic signed [NUMW:0]    dc, du;
    logic signed [2*NUMW+1:0] pc, pu;
    logic signed [3:0]       ndiff;
    logic signed [DEW-1:0]   de, neg;
    logic [TW-1:0]           t;
    logic [31:0]             pp;
    nc = 3'd0;
    nu = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (job_q.nbr_ok[i] && nbr_q[i] == cand)  nc = nc + 3'd1;
      if (job_q.nbr_ok[i] && nbr_q[i] == ctr_q) nu = nu + 3'd1;
    end
    dc    = $signed({1'b0, NUMW'(obs_q)}) - $signed({1'b0, colc_q});
    du    = $signed({1'b0, NUMW'(obs_q)}) - $signed({1'b0, colu_q});
    pc    = dc * dc;
    pu    = du * du;
    ndiff = $signed({1'b0, nc}) - $signed({1'b0, nu});
    // Stage 1: squares and neighbour term
    sqc_q   <= pc[SQW-1:0];
    squ_q   <= pu[SQW-1:0];
    agree_q <= AGW'($signed({1'b0, cfg_i.beta}) * ndiff);
    // Stage 2: data terms
    datc_q  <= DATW'(sqc_q * cfg_i.inv_two_variance);
    datu_q  <= DATW'(squ_q * cfg_i.inv_two_variance);
    // Stage 3: energy drop magnitude
    de  = (DEW'(agree_q) <<< 20) - $signed({2'b0, datc_q}) + $signed({2'b0, datu_q});
    neg = -de;
    mag_q <= de[DEW-1] ? neg[MAGW-1:0] : '0;
    // Stage 4: scale by inverse temperature in two partial products
    plo_q <= mag_q[19:0] * cfg_i.inv_temperature;
    phi_q <= mag_q[MAGW-1:20] * cfg_i.inv_temperature;
    // Stage 5: exp lookup, zero past the table
    t   = {phi_q, 20'b0} + TW'(plo_q);
    e_q <= (|t[TW-1:40]) ? 16'd0 : pmpu_pkg::EXP_TABLE[t[39:32]];
    // Stage 6: acceptance probability
    pp  = cfg_i.accept_scale * e_q;
    p_q <= pp[31:16];
  end

endmodule

FILE: src/potts_metropolis_pixel_update_core.sv
// Top level of the Potts-model Metropolis pixel update core.
// Holds the configuration registers and output register; depends on pmpu_pkg,
// pmpu_front, pmpu_queue and pmpu_back.
//
// Usage: items enter on in_valid_i/in_ready_o (in_data_i), results leave on
// out_valid_o/out_ready_i (out_data_o), one result for every item, in order.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write it only while idle, which the block does not enforce. A two-entry queue
// sits between the classifying front end and the back end. Loads and out-of-grid
// items finish at hand-off to the back end, so they stream at one per cycle while
// the output register takes results; each item passes through a queue entry and
// its result through the output register. Reads go through a hand-off, then a
// registered memory read. Proposals take the item, fetch the center and four
// neighbor labels through the single read port, run the bit-serial color divider,
// and pass the energy, exp lookup and acceptance pipeline.
// Reset clears the handshake and sequencer state and restores the register
// defaults; the memories are not cleared and must be loaded before use.
// When out_ready_i is low the result is held; the queue keeps accepting items
// until it fills.
module potts_metropolis_pixel_update_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int LABEL_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmpu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmpu_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  pmpu_pkg::cfg_t      cfg_q;
  pmpu_pkg::job_t      job_in, job_head;
  pmpu_pkg::out_item_t res, out_q;
  logic                job_valid, pop, res_valid, res_ready, out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_bins         <= 7'd10;
      cfg_q.grid_width       <= 9'd256;
      cfg_q.grid_height      <= 9'd256;
      cfg_q.beta             <= 16'd2560;
      cfg_q.inv_two_variance <= 16'd1280;
      cfg_q.inv_temperature  <= 16'd256;
      cfg_q.accept_scale     <= 16'd65535;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmpu_pkg::CFG_NUM_BINS:     cfg_q.num_bins         <= cfg_wdata_i[6:0];
        pmpu_pkg::CFG_GRID_WIDTH:   cfg_q.grid_width       <= cfg_wdata_i[8:0];
        pmpu_pkg::CFG_GRID_HEIGHT:  cfg_q.grid_height      <= cfg_wdata_i[8:0];
        pmpu_pkg::CFG_BETA:         cfg_q.beta             <= cfg_wdata_i;
        pmpu_pkg::CFG_INV_TWO_VAR:  cfg_q.inv_two_variance <= cfg_wdata_i;
        pmpu_pkg::CFG_INV_TEMP:     cfg_q.inv_temperature  <= cfg_wdata_i;
        pmpu_pkg::CFG_ACCEPT_SCALE: cfg_q.accept_scale     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pmpu_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .job_o  (job_in)
  );

  pmpu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (job_in),
    .pop_valid_o  (job_valid),
    .pop_i        (pop),
    .pop_data_o   (job_head)
  );

  pmpu_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LABEL_BITS (LABEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/pmpu_checker.sv
// Port-level checks for the Potts pixel update core, bound to the top level.
// Depends on pmpu_pkg.
module pmpu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pmpu_pkg::out_item_t out_data_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 3'd0;
    else         pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No result without an item in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without pending item");

  // Queue, back end and output register bound the items in flight
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd4 |-> !in_ready_o)
    else $error("too many items in flight");

endmodule

bind potts_metropolis_pixel_update_core pmpu_checker u_pmpu_checker (.*);
